FILE: src/sab_pkg.sv
// shared types, sizes and helper functions for the suffix automaton builder
// no dependencies
package sab_pkg;

    localparam int MAX_LEN     = 4096;
    localparam int ALPHABET    = 26;
    localparam int STATE_NUM   = 2 * MAX_LEN;
    localparam int STATE_W     = $clog2(STATE_NUM);
    localparam int LEN_W       = $clog2(MAX_LEN + 1);
    localparam int LETTER_W    = 5;
    localparam int EDGE_W      = 14;
    localparam int K_W         = $clog2(ALPHABET + 1);
    localparam int EDGE_DEPTH  = STATE_NUM * ALPHABET;
    localparam int EDGE_AW     = $clog2(EDGE_DEPTH);
    localparam int EDGE_MAX    = (1 << EDGE_W) - 1;

    typedef logic [STATE_W-1:0]  t_state;
    typedef logic [LEN_W-1:0]    t_len;
    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [EDGE_W-1:0]   t_edges;
    typedef logic [EDGE_AW-1:0]  t_eaddr;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_START,
        OP_WALK_RD,
        OP_WALK_CHK,
        OP_Q_RD,
        OP_CMP,
        OP_LINK_Q,
        OP_LINK_R,
        OP_COPY,
        OP_REDIR_RD,
        OP_REDIR_CHK,
        OP_FINISH
    } t_op;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK_RD,
        S_WALK_CHK,
        S_Q_RD,
        S_CMP,
        S_LINK_Q,
        S_LINK_R,
        S_COPY,
        S_REDIR_RD,
        S_REDIR_CHK,
        S_FINISH
    } t_fsm;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic ignore;
        logic e_zero;
        logic p_root;
        logic len_eq;
        logic copy_done;
        logic redir_hit;
        logic out_busy;
    } t_stat;

    function automatic t_eaddr edge_addr(input t_state s, input t_letter l);
        return t_eaddr'(s) * t_eaddr'(ALPHABET) + t_eaddr'(l);
    endfunction

    function automatic t_edges edge_inc(input t_edges e);
        return (e == t_edges'(EDGE_MAX)) ? e : e + t_edges'(1);
    endfunction

endpackage

FILE: src/sab_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module sab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/sab_ctrl.sv
// controller state machine sequencing the automaton update
// depends on sab_pkg
module sab_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sab_pkg::t_stat i_stat,
    output sab_pkg::t_cmd  o_cmd
);
    import sab_pkg::*;

    t_fsm r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        o_ready  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.op = OP_START;
                    n_state  = i_stat.ignore ? S_FINISH : S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                o_cmd.op = OP_WALK_RD;
                n_state  = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                o_cmd.op = OP_WALK_CHK;
                if (!i_stat.e_zero) n_state = S_Q_RD;
                else if (i_stat.p_root) n_state = S_FINISH;
                else n_state = S_WALK_RD;
            end
            S_Q_RD: begin
                o_cmd.op = OP_Q_RD;
                n_state  = S_CMP;
            end
            S_CMP: begin
                o_cmd.op = OP_CMP;
                n_state  = i_stat.len_eq ? S_FINISH : S_LINK_Q;
            end
            S_LINK_Q: begin
                o_cmd.op = OP_LINK_Q;
                n_state  = S_LINK_R;
            end
            S_LINK_R: begin
                o_cmd.op = OP_LINK_R;
                n_state  = S_COPY;
            end
            S_COPY: begin
                o_cmd.op = OP_COPY;
                if (i_stat.copy_done) n_state = S_REDIR_RD;
            end
            S_REDIR_RD: begin
                o_cmd.op = OP_REDIR_RD;
                n_state  = S_REDIR_CHK;
            end
            S_REDIR_CHK: begin
                o_cmd.op = OP_REDIR_CHK;
                if (!i_stat.redir_hit || i_stat.p_root) n_state = S_FINISH;
                else n_state = S_REDIR_RD;
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end
endmodule

FILE: src/sab_dp.sv
// datapath: automaton memories, walk registers, counters and result register
// depends on sab_pkg and sab_ram
module sab_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sab_pkg::t_cmd           i_cmd,
    output sab_pkg::t_stat          o_stat,
    input  sab_pkg::t_letter        i_letter,
    input  logic                    i_ready,
    output logic                    o_valid,
    output sab_pkg::t_state         o_state_count,
    output sab_pkg::t_edges         o_edge_count,
    output logic                    o_overflow
);
    import sab_pkg::*;

    t_eaddr  r_clr;
    t_state  r_last, r_states, r_p, r_q, r_r, r_cl;
    t_edges  r_edges;
    t_len    r_letters, r_lenp;
    t_letter r_c;
    logic    r_ovf, r_skip, r_pend, r_out_valid;
    logic [K_W-1:0] r_k;
    t_letter r_kw;
    t_state  r_out_states;
    t_edges  r_out_edges;
    logic    r_out_ovf;

    logic    e_we, l_we, n_we;
    t_eaddr  e_waddr, e_raddr;
    t_state  e_wdata, e_rdata;
    t_state  l_waddr, l_raddr, l_wdata, l_rdata;
    t_state  n_waddr, n_raddr;
    t_len    n_wdata, n_rdata;
    logic    ovf_now, ignore_now, e_zero, p_root, len_eq, copy_rd;

    sab_ram #(.WIDTH(STATE_W), .DEPTH(EDGE_DEPTH)) u_edge (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rdata)
    );
    sab_ram #(.WIDTH(STATE_W), .DEPTH(STATE_NUM)) u_link (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_raddr(l_raddr), .o_rdata(l_rdata)
    );
    sab_ram #(.WIDTH(LEN_W), .DEPTH(STATE_NUM)) u_len (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(n_waddr), .i_wdata(n_wdata),
        .i_raddr(n_raddr), .o_rdata(n_rdata)
    );

    assign ovf_now    = (r_letters >= t_len'(MAX_LEN));
    assign ignore_now = ovf_now || (i_letter >= t_letter'(ALPHABET));
    assign e_zero     = (e_rdata == '0);
    assign p_root     = (r_p == '0);
    assign len_eq     = ((r_lenp + t_len'(1)) == n_rdata);
    assign copy_rd    = (r_k < K_W'(ALPHABET));

    assign o_stat.clr_done  = (r_clr == t_eaddr'(EDGE_DEPTH - 1));
    assign o_stat.ignore    = ignore_now;
    assign o_stat.e_zero    = e_zero;
    assign o_stat.p_root    = p_root;
    assign o_stat.len_eq    = len_eq;
    assign o_stat.copy_done = !copy_rd && !r_pend;
    assign o_stat.redir_hit = (e_rdata == r_q);
    assign o_stat.out_busy  = r_out_valid && !i_ready;

    always_comb begin
        e_we    = 1'b0;
        e_waddr = edge_addr(r_p, r_c);
        e_wdata = r_r;
        e_raddr = edge_addr(r_p, r_c);
        l_we    = 1'b0;
        l_waddr = r_states;
        l_wdata = '0;
        l_raddr = r_p;
        n_we    = 1'b0;
        n_waddr = r_states;
        n_wdata = r_letters + t_len'(1);
        n_raddr = r_p;
        case (i_cmd.op)
            OP_CLEAR: begin
                e_we    = 1'b1;
                e_waddr = r_clr;
                e_wdata = '0;
            end
            OP_START: begin
                l_we = !ignore_now;
                n_we = !ignore_now;
            end
            OP_WALK_CHK: begin
                e_we = e_zero;
            end
            OP_Q_RD: begin
                l_raddr = r_q;
                n_raddr = r_q;
            end
            OP_CMP: begin
                l_we = 1'b1;
                if (len_eq) begin
                    l_waddr = r_r;
                    l_wdata = r_q;
                end else begin
                    l_wdata = l_rdata;
                    n_we    = 1'b1;
                    n_wdata = r_lenp + t_len'(1);
                end
            end
            OP_LINK_Q: begin
                l_we    = 1'b1;
                l_waddr = r_q;
                l_wdata = r_cl;
            end
            OP_LINK_R: begin
                l_we    = 1'b1;
                l_waddr = r_r;
                l_wdata = r_cl;
            end
            OP_COPY: begin
                e_raddr = edge_addr(r_q, LETTER_W'(r_k));
                e_we    = r_pend;
                e_waddr = edge_addr(r_cl, r_kw);
                e_wdata = e_rdata;
            end
            OP_REDIR_CHK: begin
                e_we    = (e_rdata == r_q);
                e_wdata = r_cl;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_last      <= '0;
            r_states    <= t_state'(1);
            r_edges     <= '0;
            r_letters   <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            if (i_cmd.op == OP_FINISH) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
            case (i_cmd.op)
                OP_CLEAR: r_clr <= r_clr + t_eaddr'(1);
                OP_START: begin
                    r_ovf  <= ovf_now;
                    r_skip <= ignore_now;
                    r_c    <= i_letter;
                    if (!ignore_now) begin
                        r_r      <= r_states;
                        r_states <= r_states + t_state'(1);
                        r_p      <= r_last;
                    end
                end
                OP_WALK_CHK: begin
                    if (e_zero) begin
                        r_edges <= edge_inc(r_edges);
                        r_p     <= l_rdata;
                    end else begin
                        r_q    <= e_rdata;
                        r_lenp <= p_root ? '0 : n_rdata;
                    end
                end
                OP_CMP: begin
                    if (!len_eq) begin
                        r_cl     <= r_states;
                        r_states <= r_states + t_state'(1);
                        r_k      <= '0;
                        r_pend   <= 1'b0;
                    end
                end
                OP_COPY: begin
                    r_pend <= copy_rd;
                    r_kw   <= LETTER_W'(r_k);
                    if (copy_rd) r_k <= r_k + K_W'(1);
                    if (r_pend && !e_zero) r_edges <= edge_inc(r_edges);
                end
                OP_REDIR_CHK: r_p <= l_rdata;
                OP_FINISH: begin
                    r_out_states <= r_states;
                    r_out_edges  <= r_edges;
                    r_out_ovf    <= r_ovf;
                    if (!r_skip) begin
                        r_last    <= r_r;
                        r_letters <= r_letters + t_len'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_state_count = r_out_states;
    assign o_edge_count  = r_out_edges;
    assign o_overflow    = r_out_ovf;

    a_states_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_states != '0) else $error("state count reached zero");
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_FINISH |=> r_out_valid) else $error("result not loaded");
    a_letters_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_letters <= t_len'(MAX_LEN)) else $error("letter count beyond bound");
endmodule

FILE: src/suffix_automaton_builder_unit.sv
// suffix automaton builder top level
// input channel: i_valid/o_ready with i_letter (0..25); output channel:
// o_valid/i_ready with o_state_count, o_edge_count, o_overflow; one result
// per accepted item
// an item is handled one at a time: a start and a finish step, one walk step
// per suffix link followed (edge, link and length memories read in
// parallel), the clone compare and link updates, the 26-word edge copy
// through the single edge memory read port, and one redirect step per
// redirected edge
// ignored letters (overflow or outside the alphabet) go straight to finish
// after reset a clearing pass writes every edge entry with o_ready low;
// counts restart at one state and zero edges
// a finished result sits in an output register; the next item is accepted
// while it waits, and the block holds before loading a new result until the
// receiver takes the old one
// depends on sab_pkg, sab_ctrl, sab_dp, sab_ram
module suffix_automaton_builder_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  sab_pkg::t_letter        i_letter,
    output logic                    o_valid,
    input  logic                    i_ready,
    output sab_pkg::t_state         o_state_count,
    output sab_pkg::t_edges         o_edge_count,
    output logic                    o_overflow
);
    import sab_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sab_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_stat(stat), .o_cmd(cmd)
    );

    sab_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_letter(i_letter), .i_ready(i_ready), .o_valid(o_valid),
        .o_state_count(o_state_count), .o_edge_count(o_edge_count),
        .o_overflow(o_overflow)
    );
endmodule

FILE: tb/suffix_automaton_builder_unit_tb.sv
// self-checking testbench for the suffix automaton builder: letters in, running
// state and edge counts out, checked against an in-bench automaton builder
// depends on sab_pkg and suffix_automaton_builder_unit
module suffix_automaton_builder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sab_pkg::*;

    localparam int STATE_SAT = 8191;
    localparam int EDGE_SAT  = 16383;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        t_state sc;
        t_edges ec;
        logic   ovf;
    } count_t;

    typedef struct {
        t_letter letter;
        bit      typed;
        count_t  res;
    } row_t;

    logic    i_clk = 0;
    logic    i_rst_n = 0;
    logic    i_valid = 0;
    logic    i_ready = 0;
    t_letter i_letter = '0;
    logic    o_ready, o_valid, o_overflow;
    t_state  o_state_count;
    t_edges  o_edge_count;

    suffix_automaton_builder_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_letter(i_letter),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_state_count(o_state_count), .o_edge_count(o_edge_count),
        .o_overflow(o_overflow)
    );

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    // automaton mirror
    int edge_tbl [0:EDGE_DEPTH-1];
    int link_tbl [0:STATE_NUM-1];
    int len_tbl [0:STATE_NUM-1];
    int last_st, st_used, ed_used, seen;
    int clone_cnt, ovf_cnt;

    count_t expected_counts[$];
    row_t   dir_rows[$];
    bit     typed_q[$];
    count_t typed_res_q[$];
    int     errors = 0;
    int     items_in = 0, results_out = 0;
    int     send_idle_pct = 0, sink_stall_pct = 0;
    int     hold_left = 0;
    bit     hold_req = 0;

    function automatic void add_edges(int n);
        ed_used = (ed_used + n > EDGE_SAT) ? EDGE_SAT : ed_used + n;
    endfunction

    function automatic count_t grow_automaton(t_letter l);
        count_t o;
        int r, p, q, cl, copied;
        bit found;
        o.ovf = 0;
        if (seen >= MAX_LEN) begin
            o.ovf = 1;
            ovf_cnt++;
        end else if (l < ALPHABET) begin
            r = st_used++;
            p = last_st;
            found = 0;
            len_tbl[r] = seen + 1;
            link_tbl[r] = 0;
            forever begin
                if (edge_tbl[p*ALPHABET + l] != 0) begin
                    found = 1;
                    break;
                end
                edge_tbl[p*ALPHABET + l] = r;
                add_edges(1);
                if (p == 0) break;
                p = link_tbl[p];
            end
            if (found) begin
                q = edge_tbl[p*ALPHABET + l];
                if (len_tbl[p] + 1 == len_tbl[q]) begin
                    link_tbl[r] = q;
                end else begin
                    cl = st_used++;
                    clone_cnt++;
                    copied = 0;
                    for (int k = 0; k < ALPHABET; k++) begin
                        edge_tbl[cl*ALPHABET + k] = edge_tbl[q*ALPHABET + k];
                        if (edge_tbl[q*ALPHABET + k] != 0) copied++;
                    end
                    add_edges(copied);
                    len_tbl[cl] = len_tbl[p] + 1;
                    link_tbl[cl] = link_tbl[q];
                    link_tbl[q] = cl;
                    link_tbl[r] = cl;
                    forever begin
                        if (edge_tbl[p*ALPHABET + l] != q) break;
                        edge_tbl[p*ALPHABET + l] = cl;
                        if (p == 0) break;
                        p = link_tbl[p];
                    end
                end
            end
            last_st = r;
            seen++;
        end
        o.sc = t_state'((st_used > STATE_SAT) ? STATE_SAT : st_used);
        o.ec = t_edges'(ed_used);
        return o;
    endfunction

    // item bookkeeping and result checking
    always @(posedge i_clk) begin
        count_t e, g, tr;
        bit is_typed;
        if (i_valid && o_ready) begin
            items_in++;
            g = grow_automaton(i_letter);
            if (typed_q.size() > 0) begin
                is_typed = typed_q.pop_front();
                tr = typed_res_q.pop_front();
                if (is_typed) g = tr;
            end
            expected_counts.push_back(g);
        end
        if (o_valid && i_ready) begin
            results_out++;
            if (expected_counts.size() == 0) begin
                $error("result with no item pending");
                errors++;
            end else begin
                e = expected_counts.pop_front();
                if (o_state_count !== e.sc) begin
                    $error("state_count expected %0d got %0d", e.sc, o_state_count);
                    errors++;
                end
                if (o_edge_count !== e.ec) begin
                    $error("edge_count expected %0d got %0d", e.ec, o_edge_count);
                    errors++;
                end
                if (o_overflow !== e.ovf) begin
                    $error("overflow expected %0d got %0d", e.ovf, o_overflow);
                    errors++;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 0;
        end else begin
            i_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_letter(t_letter l, bit typed, count_t res);
        typed_q.push_back(typed);
        typed_res_q.push_back(res);
        i_valid <= 1;
        i_letter <= l;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic t_letter rand_letter();
        int sel = $urandom_range(99);
        if (sel < 45) return t_letter'($urandom_range(1));
        if (sel < 75) return t_letter'($urandom_range(3));
        if (sel < 93) return t_letter'($urandom_range(25));
        return t_letter'($urandom_range(31));
    endfunction

    function automatic row_t mk_row(int l, bit typed = 0, int sc = 0, int ec = 0,
                                    bit ovf = 0);
        row_t r;
        r.letter = t_letter'(l);
        r.typed = typed;
        r.res.sc = t_state'(sc);
        r.res.ec = t_edges'(ec);
        r.res.ovf = ovf;
        return r;
    endfunction

    initial begin
        count_t none;
        int idle_mode [4] = '{0, 47, 0, 33};
        int stall_mode [4] = '{0, 0, 47, 33};
        none = '{sc: '0, ec: '0, ovf: 0};
        for (int i = 0; i < EDGE_DEPTH; i++) edge_tbl[i] = 0;
        for (int i = 0; i < STATE_NUM; i++) begin
            link_tbl[i] = 0;
            len_tbl[i] = 0;
        end
        last_st = 0; st_used = 1; ed_used = 0; seen = 0;
        clone_cnt = 0; ovf_cnt = 0;

        // directed rows: out-of-alphabet on empty automaton, first letters, clones
        dir_rows = {mk_row(31, 1, 1, 0, 0), mk_row(26, 1, 1, 0, 0),
                    mk_row(0, 1, 2, 1, 0), mk_row(0, 1, 3, 2, 0),
                    mk_row(1), mk_row(1), mk_row(0), mk_row(1), mk_row(25),
                    mk_row(25), mk_row(27), mk_row(0), mk_row(25), mk_row(16),
                    mk_row(15), mk_row(8), mk_row(7), mk_row(1), mk_row(0),
                    mk_row(1), mk_row(0), mk_row(2), mk_row(30)};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        foreach (dir_rows[i]) send_letter(dir_rows[i].letter, dir_rows[i].typed,
                                          dir_rows[i].res);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_mode[ph];
            sink_stall_pct = stall_mode[ph];
            if (ph == 0) hold_req = 1;
            repeat (110) send_letter(rand_letter(), 0, none);
        end

        // short tail mixing letters inside and outside the alphabet
        send_idle_pct = 10;
        sink_stall_pct = 10;
        repeat (6) send_letter(t_letter'($urandom_range(31)), 0, none);
        send_letter(t_letter'(31), 0, none);
        send_letter(t_letter'(0), 0, none);
        i_valid <= 0;

        for (int w = 0; w < 100000 && expected_counts.size() > 0; w++)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (expected_counts.size() > 0) begin
            $error("%0d results never arrived", expected_counts.size());
            errors++;
        end
        $display("%0d letters sent, %0d results checked, %0d clones, %0d past the length bound",
                 items_in, results_out, clone_cnt, ovf_cnt);
        $display("final automaton: %0d states, %0d edges", st_used, ed_used);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: suffix_automaton_builder_unit.f
src/sab_pkg.sv
src/sab_ram.sv
src/sab_ctrl.sv
src/sab_dp.sv
src/suffix_automaton_builder_unit.sv
tb/suffix_automaton_builder_unit_tb.sv
